@@ hdl/nsd_pkg.sv @@
// Package with the types, character codes and sizes shared by the sentence demux files.
`timescale 1ns / 1ps
package nsd_pkg;

  // Size of each consumer payload buffer; the terminator must stay inside it.
  localparam int unsigned BUF_DEPTH = 128;
  localparam logic [7:0]  MAX_OFFSET = 8'(BUF_DEPTH - 2);

  // Characters that steer the parser.
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_L      = 8'h4C;

  // Byte positions within a sentence; the dollar sign is position one.
  localparam logic [7:0] POS_IDLE      = 8'd0;
  localparam logic [7:0] POS_START     = 8'd1;
  localparam logic [7:0] POS_ID_FIRST  = 8'd5;
  localparam logic [7:0] POS_ID_SECOND = 8'd6;
  localparam logic [7:0] POS_PAYLOAD   = 8'd8;
  localparam logic [7:0] POS_MAX       = 8'd255;

  // Sentence type; the low two bits of the buffered types double as the store target.
  typedef enum logic [2:0] {
    TYPE_NONE = 3'd0,
    TYPE_RMC  = 3'd1,
    TYPE_GGA  = 3'd2,
    TYPE_GSA  = 3'd3,
    TYPE_GLL  = 3'd4
  } sent_type_t;

  // Store target codes toward the consumer.
  localparam logic [1:0] TGT_NONE = 2'd0;

  // One result item.
  typedef struct packed {
    logic [1:0] store_target;
    logic [6:0] store_offset;
    logic [7:0] store_byte;
    logic       gll_done;
  } nsd_result_t;

  // Map the two id characters to a type, keeping the old type when nothing matches.
  function automatic sent_type_t classify(input logic [7:0] a, input logic [7:0] b,
                                          input sent_type_t keep);
    sent_type_t t;
    t = keep;
    if (a == CH_M && b == CH_C) t = TYPE_RMC;
    else if (a == CH_G && b == CH_A) t = TYPE_GGA;
    else if (a == CH_S && b == CH_A) t = TYPE_GSA;
    else if (a == CH_L && b == CH_L) t = TYPE_GLL;
    return t;
  endfunction

endpackage

@@ hdl/nsd_if.sv @@
// Valid/ready channel interfaces for received bytes and for store commands.
`timescale 1ns / 1ps
interface nsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface nsd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] store_target;
  logic [6:0] store_offset;
  logic [7:0] store_byte;
  logic       gll_done;

  modport source (output valid, output store_target, output store_offset,
                  output store_byte, output gll_done, input ready);
  modport sink   (input valid, input store_target, input store_offset,
                  input store_byte, input gll_done, output ready);
endinterface

@@ hdl/nsd_in_stage.sv @@
// Input register that holds one received byte until the parser takes it.
`timescale 1ns / 1ps
module nsd_in_stage
  import nsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  nsd_in_if.sink     in_ch,
  input  logic       take,
  output logic       vld,
  output logic [7:0] rx_byte
);

  logic       vld_r, vld_nxt;
  logic [7:0] byte_r;
  logic       load;

  // The slot is free when empty or when its byte leaves in this cycle.
  assign in_ch.ready = !vld_r || take;
  assign load        = in_ch.valid && in_ch.ready;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (take) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Payload register needs no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= in_ch.rx_byte;
    end
  end

  assign vld     = vld_r;
  assign rx_byte = byte_r;

endmodule

@@ hdl/nsd_parser.sv @@
// Sentence state tracker: position, id latch, type, and the store command per byte.
`timescale 1ns / 1ps
module nsd_parser
  import nsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  logic [7:0]  rx_byte,
  output nsd_result_t res
);

  logic [7:0] pos_r, pos_nxt;
  logic [7:0] fid_r, fid_nxt;
  sent_type_t type_r, type_nxt;

  logic [7:0] pos_a, pos_b, off;
  sent_type_t type_a;

  always_comb begin
    // A dollar sign while idle opens a new sentence.
    pos_a  = pos_r;
    type_a = type_r;
    if (rx_byte == CH_DOLLAR && pos_r == POS_IDLE) begin
      pos_a  = POS_START;
      type_a = TYPE_NONE;
    end

    // Latch and decode the two id characters.
    fid_nxt  = fid_r;
    type_nxt = type_a;
    if (pos_a == POS_ID_FIRST) begin
      fid_nxt = rx_byte;
    end
    if (pos_a == POS_ID_SECOND) begin
      type_nxt = classify(fid_r, rx_byte, type_a);
    end

    // Carriage return ends the sentence; the type is kept for the done pulse.
    res   = '0;
    pos_b = pos_a;
    if (rx_byte == CH_CR) begin
      pos_b        = POS_IDLE;
      res.gll_done = (type_nxt == TYPE_GLL);
    end

    // Payload bytes of buffered types become store commands while they fit.
    off = pos_b - POS_PAYLOAD;
    if (pos_b >= POS_PAYLOAD && type_nxt inside {TYPE_RMC, TYPE_GGA, TYPE_GSA} &&
        off <= MAX_OFFSET) begin
      res.store_target = type_nxt[1:0];
      res.store_offset = off[6:0];
      res.store_byte   = rx_byte;
    end

    // Advance the saturating position counter.
    pos_nxt = pos_b;
    if (pos_b != POS_IDLE && pos_b != POS_MAX) begin
      pos_nxt = pos_b + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= POS_IDLE;
      fid_r  <= '0;
      type_r <= TYPE_NONE;
    end else if (adv) begin
      pos_r  <= pos_nxt;
      fid_r  <= fid_nxt;
      type_r <= type_nxt;
    end
  end

endmodule

@@ hdl/nmea_sentence_demux_top.sv @@
// Top level of the sentence demux: input register, parser and result register.
//
//   Channel  Direction  Contents
//   in_ch    sink       rx_byte (8b): one received serial character per request
//   out_ch   source     store_target (2b), store_offset (7b), store_byte (8b), gll_done (1b)
//
// Each request gives exactly one result, which passes through the input register and then the result register.
// One request per cycle is sustained while out_ch.ready stays high; the input register and the result register each
// hold one request, so a new byte is taken while a finished result waits.
// Reset (rst_n low, synchronous) empties both registers and returns the parser to idle.
// A stalled output holds its result and fills the input register before in_ch.ready drops.
`timescale 1ns / 1ps
module nmea_sentence_demux_top
  import nsd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  nsd_in_if.sink   in_ch,
  nsd_out_if.source out_ch
);

  logic        s1_vld;
  logic [7:0]  s1_byte;
  logic        adv;
  nsd_result_t res;

  logic        out_vld_r, out_vld_nxt;
  nsd_result_t out_r;

  // The parser consumes the held byte when the result register can take its result.
  assign adv = s1_vld && (!out_vld_r || out_ch.ready);

  nsd_in_stage u_in (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .take    (adv),
    .vld     (s1_vld),
    .rx_byte (s1_byte)
  );

  nsd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .rx_byte (s1_byte),
    .res     (res)
  );

  // Result register valid flag.
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (adv) begin
      out_vld_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= res;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.store_target = out_r.store_target;
  assign out_ch.store_offset = out_r.store_offset;
  assign out_ch.store_byte   = out_r.store_byte;
  assign out_ch.gll_done     = out_r.gll_done;

  // A store never lands where its terminator would fall outside the buffer.
  a_offset_fits: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_r.store_target != TGT_NONE |->
      {1'b0, out_r.store_offset} <= MAX_OFFSET)
    else $error("store offset beyond buffer");

  // A carriage return never produces a store, so done and store are exclusive.
  a_done_no_store: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_r.gll_done |-> out_r.store_target == TGT_NONE)
    else $error("gll_done together with a store");

  // Results without a store carry zero offset and byte.
  a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_r.store_target == TGT_NONE |->
      out_r.store_offset == '0 && out_r.store_byte == '0)
    else $error("nonzero fields without a store");

  // A held byte moves into a free result register in the next cycle.
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld && (!out_vld_r || out_ch.ready) |=> out_vld_r)
    else $error("result lost on advance");

  // While the output stalls, the input register is not drained.
  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_ch.ready && s1_vld |=> s1_vld && $stable(s1_byte))
    else $error("input byte dropped during stall");

endmodule

@@ tb/tb_nmea_sentence_demux_top.sv @@
// Self-checking testbench for the NMEA sentence demux: sentence stimulus, store command checks.
`timescale 1ns / 1ps
module tb_nmea_sentence_demux_top;
  import nsd_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned PHASE_ITEMS   = 375;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned SETTLE_CYCLES = 16;

  // Tracks the parser state and holds the store commands still owed by the block.
  class store_cmd_book;
    logic [7:0]  pos;
    logic [7:0]  id_first;
    sent_type_t  stype;
    nsd_result_t expected_stores[$];
    int unsigned mismatches;

    function new();
      pos        = POS_IDLE;
      id_first   = '0;
      stype      = TYPE_NONE;
      mismatches = 0;
    endfunction

    function int pending();
      return expected_stores.size();
    endfunction

    // Advance the parser by one received byte and queue the store command it causes.
    function void take_byte(logic [7:0] c);
      nsd_result_t r;
      logic [7:0]  off;
      r = '0;
      if (c == CH_DOLLAR && pos == POS_IDLE) begin
        pos   = POS_START;
        stype = TYPE_NONE;
      end
      if (pos == POS_ID_FIRST) id_first = c;
      // An id that matches nothing leaves the earlier type in place.
      if (pos == POS_ID_SECOND) begin
        case ({id_first, c})
          {CH_M, CH_C}: stype = TYPE_RMC;
          {CH_G, CH_A}: stype = TYPE_GGA;
          {CH_S, CH_A}: stype = TYPE_GSA;
          {CH_L, CH_L}: stype = TYPE_GLL;
          default: ;
        endcase
      end
      if (c == CH_CR) begin
        pos = POS_IDLE;
        if (stype == TYPE_GLL) r.gll_done = 1'b1;
      end
      // Payload of buffered types is stored as long as the terminator still fits.
      if (pos >= POS_PAYLOAD) begin
        off = pos - POS_PAYLOAD;
        if (stype != TYPE_NONE && stype != TYPE_GLL && off <= MAX_OFFSET) begin
          r.store_target = stype[1:0];
          r.store_offset = off[6:0];
          r.store_byte   = c;
        end
      end
      if (pos != POS_IDLE && pos != POS_MAX) pos = pos + 8'd1;
      expected_stores.push_back(r);
    endfunction

    function void compare_field(string name, int exp_val, int act_val);
      if (exp_val != act_val) begin
        $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
        mismatches++;
      end
    endfunction

    // Compare one accepted store command with the oldest one owed.
    function void check_store(nsd_result_t got);
      nsd_result_t want;
      if (expected_stores.size() == 0) begin
        $error("store command with none owed: target %0d, offset %0d, byte %0d, done %0d",
               got.store_target, got.store_offset, got.store_byte, got.gll_done);
        mismatches++;
        return;
      end
      want = expected_stores.pop_front();
      compare_field("store_target", want.store_target, got.store_target);
      compare_field("store_offset", want.store_offset, got.store_offset);
      compare_field("store_byte", want.store_byte, got.store_byte);
      compare_field("gll_done", want.gll_done, got.gll_done);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  nsd_in_if  in_ch ();
  nsd_out_if out_ch ();

  store_cmd_book book = new();
  int unsigned   send_idle_pct;
  int unsigned   recv_stall_pct;
  int unsigned   hold_left;
  int unsigned   bytes_sent;
  int unsigned   cycle_count;

  nmea_sentence_demux_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog on the whole run.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off when one is requested.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left = hold_left - 1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Check every accepted store command.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      book.check_store('{store_target: out_ch.store_target, store_offset: out_ch.store_offset,
                         store_byte: out_ch.store_byte, gll_done: out_ch.gll_done});
  end

  // Offer one byte, with random idle cycles ahead of it, and wait for the handshake.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    book.take_byte(b);
    bytes_sent++;
  endtask

  // Stop offering and wait until every owed store command has come out.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (book.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] payload_char();
    logic [7:0] c;
    c = 8'($urandom_range(255));
    if ($urandom_range(19) == 0) c = CH_DOLLAR;
    if (c == CH_CR) c = 8'h0C;
    return c;
  endfunction

  // One sentence: mostly well formed with random payload, some noise and cut-off ones.
  task automatic send_sentence();
    int unsigned kind;
    int unsigned len;
    logic [7:0]  id1;
    logic [7:0]  id2;
    kind = $urandom_range(99);
    if (kind < 82) begin
      case ($urandom_range(4))
        0: begin id1 = CH_M; id2 = CH_C; end
        1: begin id1 = CH_G; id2 = CH_A; end
        2: begin id1 = CH_S; id2 = CH_A; end
        3: begin id1 = CH_L; id2 = CH_L; end
        default: begin
          id1 = ($urandom_range(1) == 0) ? CH_M : 8'($urandom_range(255));
          id2 = ($urandom_range(1) == 0) ? CH_A : 8'($urandom_range(255));
        end
      endcase
      len = ($urandom_range(29) == 0) ? $urandom_range(120, 300) : $urandom_range(0, 30);
      send_byte(CH_DOLLAR);
      send_byte("G");
      send_byte("P");
      send_byte(8'($urandom_range(8'h41, 8'h5A)));
      send_byte(id1);
      send_byte(id2);
      send_byte(",");
      repeat (len) send_byte(payload_char());
      send_byte(CH_CR);
    end else if (kind < 91) begin
      // Loose bytes between sentences, carriage returns among them.
      repeat ($urandom_range(1, 4))
        send_byte(($urandom_range(3) == 0) ? CH_CR : 8'($urandom_range(255)));
    end else begin
      // Sentence cut short inside its header.
      send_byte(CH_DOLLAR);
      repeat ($urandom_range(0, 6)) send_byte(payload_char());
      send_byte(CH_CR);
    end
  endtask

  initial begin
    logic [7:0] directed[];
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.rx_byte  <= '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 0;
    bytes_sent     = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Extreme bytes while idle, a lone return, a GLL sentence and a second return after
    // it, then an RMC sentence with a dollar sign as payload.
    directed = '{8'h00, 8'hFF, CH_CR,
                 CH_DOLLAR, "G", "P", "G", CH_L, CH_L, CH_CR,
                 CH_CR,
                 CH_DOLLAR, "G", "P", "R", CH_M, CH_C, ",", CH_DOLLAR, "7", CH_CR};
    foreach (directed[i]) send_byte(directed[i]);
    wait_drained();

    // Random sentences under four idling mixes; the first also sees a long output hold.
    for (int phase = 0; phase < 4; phase++) begin
      int unsigned goal;
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      if (phase == 0) hold_left = HOLD_CYCLES;
      goal = bytes_sent + PHASE_ITEMS;
      while (bytes_sent < goal) send_sentence();
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (book.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
